// File: hdl/fpa_pkg.sv
// fpa_pkg: constants, operation codes and status codes for the fixed-point alu
// used by fixed_point_alu_unit; no dependencies
`default_nettype none
package fpa_pkg;

   localparam int FracBitsDefault = 8;
   localparam int WordBitsDefault = 32;
   localparam int IoBits          = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
      OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14
   } op_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

endpackage
`default_nettype wire

// File: hdl/fixed_point_alu_unit.sv
// fixed_point_alu_unit: top level of the signed fixed-point alu
// depends on fpa_pkg and fpa_div_cell
//
// usage: req_valid/req_ready carry one item (req_func, req_operand_a,
//   req_operand_b); rsp_valid/rsp_ready return one item per request
//   (rsp_result_raw, rsp_compare_flag, rsp_status).
// every item, whatever its operation, travels the same pipeline: an input
//   register, a row of divide cells (one quotient bit per cell, WORD_BITS+
//   FRAC_BITS+1 cells), a multiply stage and an output register; results
//   leave in order.
// one item is taken per cycle while the output is not stalled; the depth is set by the divide chain.
// the whole pipeline advances when the output register is empty or being
//   taken; while a result waits on a stalled receiver every stage freezes
//   and req_ready is low.
// reset clears all valid bits; no memory needs a clearing pass.
//
`default_nettype none
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
   parameter int WORD_BITS = fpa_pkg::WordBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_result_raw,
   output logic             rsp_compare_flag,
   output logic [1:0]       rsp_status
);
   localparam int IB   = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int W    = WORD_BITS;
   localparam int MB   = W + 1;              // magnitude bits
   localparam int NB   = MB + FRAC_BITS;     // dividend bits
   localparam int NC   = NB;                 // cells in the chain
   localparam int TB   = 4 + 2 * W;          // func + operands
   localparam int PB   = 2 * MB;             // product bits

   logic adv;
   logic out_v_ff;

   // pipeline advances whenever output register can take a new value
   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = adv;

   // input register: sign-extend operands
   logic          s0_v_ff;
   logic [3:0]    s0_f_ff;
   logic [W-1:0]  s0_a_ff, s0_b_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
      end
      if (adv) begin
         s0_f_ff <= req_func;
         s0_a_ff <= W'($signed(req_operand_a[IB-1:0]));
         s0_b_ff <= W'($signed(req_operand_b[IB-1:0]));
      end
   end

   // magnitudes for the divide chain
   logic [MB-1:0] ma0, mb0;
   always_comb begin
      ma0 = s0_a_ff[W-1] ? MB'(-$signed({s0_a_ff[W-1], s0_a_ff}))
                         : {1'b0, s0_a_ff};
      mb0 = s0_b_ff[W-1] ? MB'(-$signed({s0_b_ff[W-1], s0_b_ff}))
                         : {1'b0, s0_b_ff};
   end

   // row of divide cells
   logic          cv  [NC+1];
   logic [MB:0]   crem[NC+1];
   logic [NB-1:0] cnum[NC+1];
   logic [MB-1:0] cden[NC+1];
   logic [TB-1:0] ctag[NC+1];
   assign cv[0]   = s0_v_ff;
   assign crem[0] = '0;
   assign cnum[0] = NB'({ma0, {FRAC_BITS{1'b0}}});
   assign cden[0] = mb0;
   assign ctag[0] = {s0_f_ff, s0_a_ff, s0_b_ff};

   for (genvar i = 0; i < NC; i++) begin : g_cell
      fpa_div_cell #(.MAG_BITS(MB), .NUM_BITS(NB), .TAG_BITS(TB)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .v_i(cv[i]), .rem_i(crem[i]), .num_i(cnum[i]), .den_i(cden[i]),
         .tag_i(ctag[i]),
         .v_o(cv[i+1]), .rem_o(crem[i+1]), .num_o(cnum[i+1]),
         .den_o(cden[i+1]), .tag_o(ctag[i+1])
      );
   end

   // chain end: unpack, multiply stage
   logic [3:0]    e_f;
   logic [W-1:0]  e_a, e_b;
   logic [MB-1:0] ema, emb;
   assign {e_f, e_a, e_b} = ctag[NC];
   always_comb begin
      ema = e_a[W-1] ? MB'(-$signed({e_a[W-1], e_a})) : {1'b0, e_a};
      emb = e_b[W-1] ? MB'(-$signed({e_b[W-1], e_b})) : {1'b0, e_b};
   end

   logic          m_v_ff;
   logic [3:0]    m_f_ff;
   logic [W-1:0]  m_a_ff, m_b_ff;
   logic [PB-1:0] m_p_ff;
   logic [NB-1:0] m_q_ff;
   logic [MB:0]   m_r_ff;
   logic [MB-1:0] m_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= cv[NC];
      end
      if (adv) begin
         m_f_ff <= e_f;
         m_a_ff <= e_a;
         m_b_ff <= e_b;
         m_p_ff <= PB'(ema) * PB'(emb);
         m_q_ff <= cnum[NC];
         m_r_ff <= crem[NC];
         m_d_ff <= cden[NC];
      end
   end

   // final stage: round, saturate, compare, select
   localparam int XB = PB + 2;
   logic [XB-1:0] mag, lim;
   logic          neg, lt_ab, lt_ba, sat, arith;
   logic [W-1:0]  res;
   logic [W:0]    sum;
   logic          flag;
   logic [1:0]    st;
   logic [MB:0]   dif;
   always_comb begin
      lt_ab = $signed(m_a_ff) < $signed(m_b_ff);
      lt_ba = $signed(m_b_ff) < $signed(m_a_ff);
      neg   = m_a_ff[W-1] ^ m_b_ff[W-1];
      mag   = '0;
      arith = 1'b0;
      sum   = '0;
      res   = '0;
      flag  = 1'b0;
      st    = fpa_pkg::ST_OK;
      dif   = (MB+1)'(m_d_ff) - m_r_ff;
      case (m_f_ff)
         fpa_pkg::OP_ADD: sum = {m_a_ff[W-1], m_a_ff} + {m_b_ff[W-1], m_b_ff};
         fpa_pkg::OP_SUB: sum = {m_a_ff[W-1], m_a_ff} - {m_b_ff[W-1], m_b_ff};
         fpa_pkg::OP_INC: sum = {m_a_ff[W-1], m_a_ff} + (W+1)'(1);
         fpa_pkg::OP_DEC: sum = {m_a_ff[W-1], m_a_ff} - (W+1)'(1);
         fpa_pkg::OP_MUL: begin
            arith = 1'b1;
            if (FRAC_BITS > 0)
               mag = (XB'(m_p_ff) + (XB'(1) << (FRAC_BITS > 0 ? FRAC_BITS-1 : 0)))
                     >> FRAC_BITS;
            else
               mag = XB'(m_p_ff);
         end
         fpa_pkg::OP_DIV: begin
            if (m_d_ff == '0) begin
               st = fpa_pkg::ST_DIV0;
            end else begin
               arith = 1'b1;
               mag = XB'(m_q_ff) + XB'(m_r_ff >= dif);
            end
         end
         fpa_pkg::OP_GT: flag = lt_ba;
         fpa_pkg::OP_LT: flag = lt_ab;
         fpa_pkg::OP_GE: flag = !lt_ab;
         fpa_pkg::OP_LE: flag = !lt_ba;
         fpa_pkg::OP_EQ: flag = m_a_ff == m_b_ff;
         fpa_pkg::OP_NE: flag = m_a_ff != m_b_ff;
         fpa_pkg::OP_MIN: res = lt_ab ? m_a_ff : m_b_ff;
         fpa_pkg::OP_MAX: res = lt_ba ? m_a_ff : m_b_ff;
         fpa_pkg::OP_TOINT: res = W'($signed(m_a_ff) >>> FRAC_BITS);
         default: ;
      endcase
      // add/sub/inc/dec: signed overflow from the extra bit
      if (m_f_ff == fpa_pkg::OP_ADD || m_f_ff == fpa_pkg::OP_SUB ||
          m_f_ff == fpa_pkg::OP_INC || m_f_ff == fpa_pkg::OP_DEC) begin
         if (sum[W] != sum[W-1]) begin
            st  = fpa_pkg::ST_SAT;
            res = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            res = sum[W-1:0];
         end
      end
      // mul/div: apply sign and clamp
      lim = neg ? (XB'(1) << (W-1)) : ((XB'(1) << (W-1)) - XB'(1));
      sat = mag > lim;
      if (arith) begin
         if (sat) begin
            st  = fpa_pkg::ST_SAT;
            res = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            res = neg ? W'(-mag) : W'(mag);
         end
      end
   end

   // output register
   logic [31:0] o_r_ff;
   logic        o_f_ff;
   logic [1:0]  o_s_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= m_v_ff;
      end
      if (adv) begin
         o_r_ff <= 32'($signed(res));
         o_f_ff <= flag;
         o_s_ff <= st;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_result_raw   = o_r_ff;
   assign rsp_compare_flag = o_f_ff;
   assign rsp_status       = o_s_ff;
endmodule
`default_nettype wire

// File: hdl/fpa_div_cell.sv
// fpa_div_cell: one restoring-division step of the divide chain, registered
// no dependencies; instantiated by fixed_point_alu_unit
`default_nettype none
module fpa_div_cell #(
   parameter int MAG_BITS = 33,
   parameter int NUM_BITS = 41,
   parameter int TAG_BITS = 40
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                v_i,
   input  wire logic [MAG_BITS:0]   rem_i,
   input  wire logic [NUM_BITS-1:0] num_i,
   input  wire logic [MAG_BITS-1:0] den_i,
   input  wire logic [TAG_BITS-1:0] tag_i,
   output logic                     v_o,
   output logic [MAG_BITS:0]        rem_o,
   output logic [NUM_BITS-1:0]      num_o,
   output logic [MAG_BITS-1:0]      den_o,
   output logic [TAG_BITS-1:0]      tag_o
);
   logic [MAG_BITS:0]   sh;
   logic [MAG_BITS:0]   rem_in;
   logic [NUM_BITS-1:0] num_in;
   logic                v_ff;
   logic [MAG_BITS:0]   rem_ff;
   logic [NUM_BITS-1:0] num_ff;
   logic [MAG_BITS-1:0] den_ff;
   logic [TAG_BITS-1:0] tag_ff;

   // shift in next numerator bit, subtract if it fits; quotient bit enters at the bottom
   always_comb begin
      sh = {rem_i[MAG_BITS-1:0], num_i[NUM_BITS-1]};
      if (sh >= {1'b0, den_i}) begin
         rem_in = sh - {1'b0, den_i};
         num_in = {num_i[NUM_BITS-2:0], 1'b1};
      end else begin
         rem_in = sh;
         num_in = {num_i[NUM_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= v_i;
      end
      if (adv) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_i;
         tag_ff <= tag_i;
      end
   end

   assign v_o   = v_ff;
   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign tag_o = tag_ff;
endmodule
`default_nettype wire
